// ===== rtl/rsrp_pkg.sv =====
// ----------------------------------------------------------------------------
// rsrp_pkg
// Shared types and codes for the reversing speed ramp profile generator.
// ----------------------------------------------------------------------------
package rsrp_pkg;

  localparam int unsigned SpeedW  = 16;
  localparam int unsigned CmdW    = 15;
  localparam int unsigned StepW   = 15;
  localparam int unsigned TimerW  = 16;
  localparam int unsigned ActionW = 2;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 24;

  localparam logic [StepW-1:0]  RampStepRst  = 15'd256;
  localparam logic [TimerW-1:0] HoldRst      = 16'd100;
  localparam logic [TimerW-1:0] DwellRst     = 16'd25;
  localparam logic [TimerW-1:0] TimerMax     = 16'hFFFF;

  typedef enum logic [ActionW-1:0] {
    ACT_TICK    = 2'd0,
    ACT_ABORT   = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_NOP     = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    PH_RAMP_UP   = 2'd0,
    PH_HOLD      = 2'd1,
    PH_RAMP_DOWN = 2'd2,
    PH_DWELL     = 2'd3
  } phase_t;

  localparam logic [CfgAddrW-1:0] REG_RAMP_STEP = 2'd0;
  localparam logic [CfgAddrW-1:0] REG_HOLD      = 2'd1;
  localparam logic [CfgAddrW-1:0] REG_DWELL     = 2'd2;

  typedef struct packed {
    phase_t                    phase;
    logic                      reverse;
    logic signed [SpeedW-1:0]  target;
    logic [TimerW-1:0]         timer;
  } prof_state_t;

  typedef struct packed {
    logic                      reverse_sign;
    phase_t                    profile_phase;
    logic                      stop_pulse;
    logic                      target_valid;
    logic signed [SpeedW-1:0]  target_speed;
  } prof_result_t;

  typedef struct packed {
    logic [StepW-1:0]  ramp_step;
    logic [TimerW-1:0] hold_periods;
    logic [TimerW-1:0] dwell_periods;
  } prof_cfg_t;

endpackage

// ===== rtl/reversing_speed_ramp_profile_top.sv =====
// ----------------------------------------------------------------------------
// reversing_speed_ramp_profile_top
// Reversing trapezoidal speed ramp generator with stream ports.
// ----------------------------------------------------------------------------
// One word in gives one word out. A word is captured in an input register,
// the profile step is evaluated in a single combinational pass from that
// register and the profile state, and the result is then registered in the
// output register; a new word is taken every cycle while the output side
// keeps up. Only the output register's backpressure stalls the input. The
// user must write configuration registers through the cfg port only while no
// word is in flight; the block itself does not enforce this.
module reversing_speed_ramp_profile_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [rsrp_pkg::CfgAddrW-1:0]      cfg_addr,
  input  logic [rsrp_pkg::CfgDataW-1:0]      cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [14:0] command_speed, [15] zero fill
  input  logic [rsrp_pkg::InDataW-1:0]       in_tdata,
  // [1:0] action
  input  logic [rsrp_pkg::ActionW-1:0]       in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [15:0] target_speed, [16] target_valid, [17] stop_pulse,
  // [19:18] profile_phase, [20] reverse_sign, [23:21] zero fill
  output logic [rsrp_pkg::OutDataW-1:0]      out_tdata
);

  rsrp_pkg::prof_cfg_t             cfg_r;
  rsrp_pkg::prof_state_t           state_r;
  rsrp_pkg::prof_state_t           state_nxt;
  rsrp_pkg::prof_result_t          result;
  rsrp_pkg::prof_result_t          res_r;
  logic                            s1_valid_r;
  rsrp_pkg::action_t               s1_action_r;
  logic [rsrp_pkg::CmdW-1:0]       s1_cmd_r;
  logic                            out_valid_r;
  logic                            out_free;
  logic                            s1_move;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_move   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ramp_step     <= rsrp_pkg::RampStepRst;
      cfg_r.hold_periods  <= rsrp_pkg::HoldRst;
      cfg_r.dwell_periods <= rsrp_pkg::DwellRst;
    end else if (cfg_we) begin
      case (cfg_addr)
        rsrp_pkg::REG_RAMP_STEP: cfg_r.ramp_step     <= cfg_wdata[rsrp_pkg::StepW-1:0];
        rsrp_pkg::REG_HOLD:      cfg_r.hold_periods  <= cfg_wdata;
        rsrp_pkg::REG_DWELL:     cfg_r.dwell_periods <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_action_r <= rsrp_pkg::action_t'(in_tuser);
      s1_cmd_r    <= in_tdata[rsrp_pkg::CmdW-1:0];
    end
  end

  rsrp_step u_step (
    .cur_state     (state_r),
    .cfg           (cfg_r),
    .action        (s1_action_r),
    .command_speed (s1_cmd_r),
    .nxt_state     (state_nxt),
    .result        (result)
  );

  // Profile state advances exactly when a word leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase   <= rsrp_pkg::PH_RAMP_UP;
      state_r.reverse <= 1'b0;
      state_r.target  <= '0;
      state_r.timer   <= '0;
    end else if (s1_move) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, res_r};

`ifndef SYNTHESIS
  a_tready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled while output register is empty");

  a_dwell_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.phase == rsrp_pkg::PH_DWELL |-> state_r.target == '0)
    else $error("nonzero target during dwell");

  a_target_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.target != 16'sh8000)
    else $error("target left the symmetric speed range");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.target_valid |-> res_r.target_speed == '0)
    else $error("target speed nonzero on a word without a target");
`endif

endmodule

// ===== rtl/rsrp_step.sv =====
// ----------------------------------------------------------------------------
// rsrp_step
// One profile step: clamped ramp toward goal or zero and phase/timer advance.
// ----------------------------------------------------------------------------
module rsrp_step (
  input  rsrp_pkg::prof_state_t        cur_state,
  input  rsrp_pkg::prof_cfg_t          cfg,
  input  rsrp_pkg::action_t            action,
  input  logic [rsrp_pkg::CmdW-1:0]    command_speed,
  output rsrp_pkg::prof_state_t        nxt_state,
  output rsrp_pkg::prof_result_t       result
);

  logic signed [rsrp_pkg::SpeedW-1:0]   goal;
  logic signed [rsrp_pkg::SpeedW-1:0]   aim;
  logic signed [rsrp_pkg::SpeedW+1:0]   cur_ext;
  logic signed [rsrp_pkg::SpeedW+1:0]   aim_ext;
  logic signed [rsrp_pkg::SpeedW+1:0]   step_ext;
  logic signed [rsrp_pkg::SpeedW+1:0]   sum;
  logic signed [rsrp_pkg::SpeedW+1:0]   dif;
  logic signed [rsrp_pkg::SpeedW-1:0]   moved;
  logic [rsrp_pkg::TimerW-1:0]          timer_inc;

  always_comb begin
    goal = cur_state.reverse ? -$signed({1'b0, command_speed})
                             :  $signed({1'b0, command_speed});
    aim  = (cur_state.phase == rsrp_pkg::PH_RAMP_DOWN) ? '0 : goal;

    cur_ext  = {{2{cur_state.target[rsrp_pkg::SpeedW-1]}}, cur_state.target};
    aim_ext  = {{2{aim[rsrp_pkg::SpeedW-1]}}, aim};
    step_ext = $signed({3'b000, cfg.ramp_step});
    sum      = cur_ext + step_ext;
    dif      = cur_ext - step_ext;

    // Step by at most ramp_step, never past the aim.
    if (cur_ext < aim_ext) begin
      moved = (sum > aim_ext) ? aim : sum[rsrp_pkg::SpeedW-1:0];
    end else if (cur_ext > aim_ext) begin
      moved = (dif < aim_ext) ? aim : dif[rsrp_pkg::SpeedW-1:0];
    end else begin
      moved = cur_state.target;
    end

    timer_inc = (cur_state.timer == rsrp_pkg::TimerMax) ? cur_state.timer
                                                        : cur_state.timer + 1'b1;
  end

  always_comb begin
    nxt_state           = cur_state;
    result.target_speed = '0;
    result.target_valid = 1'b0;
    result.stop_pulse   = 1'b0;

    case (action)
      rsrp_pkg::ACT_ABORT: begin
        result.stop_pulse = 1'b1;
      end
      rsrp_pkg::ACT_RESTART: begin
        nxt_state.phase   = rsrp_pkg::PH_RAMP_UP;
        nxt_state.reverse = 1'b0;
        nxt_state.target  = '0;
        nxt_state.timer   = '0;
      end
      rsrp_pkg::ACT_TICK: begin
        result.target_valid = 1'b1;
        case (cur_state.phase)
          rsrp_pkg::PH_RAMP_UP: begin
            nxt_state.target    = moved;
            result.target_speed = moved;
            if (moved == goal) begin
              nxt_state.phase = rsrp_pkg::PH_HOLD;
              nxt_state.timer = '0;
            end
          end
          rsrp_pkg::PH_HOLD: begin
            nxt_state.target    = moved;
            result.target_speed = moved;
            nxt_state.timer     = timer_inc;
            if (timer_inc >= cfg.hold_periods) begin
              nxt_state.phase = rsrp_pkg::PH_RAMP_DOWN;
            end
          end
          rsrp_pkg::PH_RAMP_DOWN: begin
            nxt_state.target    = moved;
            result.target_speed = moved;
            if (moved == '0) begin
              nxt_state.phase = rsrp_pkg::PH_DWELL;
              nxt_state.timer = '0;
            end
          end
          default: begin
            nxt_state.timer = timer_inc;
            if (timer_inc >= cfg.dwell_periods) begin
              result.stop_pulse = 1'b1;
              nxt_state.reverse = ~cur_state.reverse;
              nxt_state.phase   = rsrp_pkg::PH_RAMP_UP;
            end
          end
        endcase
      end
      default: begin
      end
    endcase

    result.profile_phase = nxt_state.phase;
    result.reverse_sign  = nxt_state.reverse;
  end

endmodule

// ===== dv/tb_reversing_speed_ramp_profile_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_reversing_speed_ramp_profile_top
// Self-checking bench for the reversing speed ramp profile generator.
// ----------------------------------------------------------------------------
// Words are driven on the input stream together with a bit-exact profile
// predictor. Every word that is accepted pushes one expected result. Each
// output word is checked field by field against the oldest expected result.
// A directed pass covers the register extremes and the abort, restart, no-op,
// zero-step and goal-change cases. Random profile runs under several register
// settings follow, then a long output stall and a final run with no idling.
// ----------------------------------------------------------------------------
module tb_reversing_speed_ramp_profile_top;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_we;
  logic [rsrp_pkg::CfgAddrW-1:0] cfg_addr;
  logic [rsrp_pkg::CfgDataW-1:0] cfg_wdata;
  logic                          in_tvalid;
  logic                          in_tready;
  // [14:0] command_speed, [15] zero fill
  logic [rsrp_pkg::InDataW-1:0]  in_tdata;
  // [1:0] action
  logic [rsrp_pkg::ActionW-1:0]  in_tuser;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  // [15:0] target_speed, [16] target_valid, [17] stop_pulse,
  // [19:18] profile_phase, [20] reverse_sign, [23:21] zero fill
  logic [rsrp_pkg::OutDataW-1:0] out_tdata;

  // Predicted profile state and register copies.
  rsrp_pkg::phase_t prof_phase;
  bit               prof_reverse;
  int               prof_target;
  int               prof_timer;
  int               reg_ramp_step;
  int               reg_hold;
  int               reg_dwell;

  rsrp_pkg::prof_result_t results_due[$];
  rsrp_pkg::prof_result_t got_word;
  rsrp_pkg::prof_result_t due_word;
  int                     mismatch_count = 0;
  bit                     idle_on = 1'b1;
  int                     stall_requests = 0;
  int                     stall_grants = 0;
  int                     rx_wait = 0;

  reversing_speed_ramp_profile_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int step_toward(int cur, int goal, int step);
    if (cur < goal) begin
      cur += step;
      return (cur > goal) ? goal : cur;
    end
    if (cur > goal) begin
      cur -= step;
      return (cur < goal) ? goal : cur;
    end
    return cur;
  endfunction

  function automatic void clear_profile();
    prof_phase   = rsrp_pkg::PH_RAMP_UP;
    prof_reverse = 1'b0;
    prof_target  = 0;
    prof_timer   = 0;
  endfunction

  // Applies one word to the predicted state and returns the result it causes.
  function automatic rsrp_pkg::prof_result_t advance_profile(
    rsrp_pkg::action_t act, logic [rsrp_pkg::CmdW-1:0] cmd);
    rsrp_pkg::prof_result_t r;
    int                     goal;
    r    = '0;
    goal = prof_reverse ? -int'(cmd) : int'(cmd);
    case (act)
      rsrp_pkg::ACT_ABORT: begin
        r.stop_pulse = 1'b1;
      end
      rsrp_pkg::ACT_RESTART: begin
        clear_profile();
      end
      rsrp_pkg::ACT_TICK: begin
        r.target_valid = 1'b1;
        case (prof_phase)
          rsrp_pkg::PH_RAMP_UP: begin
            prof_target = step_toward(prof_target, goal, reg_ramp_step);
            r.target_speed = prof_target[rsrp_pkg::SpeedW-1:0];
            if (prof_target == goal) begin
              prof_phase = rsrp_pkg::PH_HOLD;
              prof_timer = 0;
            end
          end
          rsrp_pkg::PH_HOLD: begin
            prof_target = step_toward(prof_target, goal, reg_ramp_step);
            r.target_speed = prof_target[rsrp_pkg::SpeedW-1:0];
            if (prof_timer < int'(rsrp_pkg::TimerMax)) prof_timer++;
            if (prof_timer >= reg_hold) prof_phase = rsrp_pkg::PH_RAMP_DOWN;
          end
          rsrp_pkg::PH_RAMP_DOWN: begin
            prof_target = step_toward(prof_target, 0, reg_ramp_step);
            r.target_speed = prof_target[rsrp_pkg::SpeedW-1:0];
            if (prof_target == 0) begin
              prof_phase = rsrp_pkg::PH_DWELL;
              prof_timer = 0;
            end
          end
          default: begin
            if (prof_timer < int'(rsrp_pkg::TimerMax)) prof_timer++;
            if (prof_timer >= reg_dwell) begin
              r.stop_pulse = 1'b1;
              prof_reverse = ~prof_reverse;
              prof_phase   = rsrp_pkg::PH_RAMP_UP;
            end
          end
        endcase
      end
      default: ;
    endcase
    r.profile_phase = prof_phase;
    r.reverse_sign  = prof_reverse;
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance,
  // with in_tvalid still high.
  task automatic send_word(rsrp_pkg::action_t act, logic [rsrp_pkg::CmdW-1:0] cmd);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, cmd};
    in_tuser  <= act;
    do @(posedge clk); while (!in_tready);
    results_due.push_back(advance_profile(act, cmd));
    @(negedge clk);
  endtask

  // Lets the block run empty so that registers can be written safely.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [rsrp_pkg::CfgAddrW-1:0] addr,
                           logic [rsrp_pkg::CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (addr)
      rsrp_pkg::REG_RAMP_STEP: reg_ramp_step = int'(data[rsrp_pkg::StepW-1:0]);
      rsrp_pkg::REG_HOLD:      reg_hold      = int'(data);
      rsrp_pkg::REG_DWELL:     reg_dwell     = int'(data);
      default: ;
    endcase
  endtask

  task automatic set_profile(int step, int hold, int dwell);
    drain();
    write_reg(rsrp_pkg::REG_RAMP_STEP, rsrp_pkg::CfgDataW'(step));
    write_reg(rsrp_pkg::REG_HOLD, rsrp_pkg::CfgDataW'(hold));
    write_reg(rsrp_pkg::REG_DWELL, rsrp_pkg::CfgDataW'(dwell));
  endtask

  // A few ticks under the reset values of the registers.
  task automatic test_reset_values();
    send_word(rsrp_pkg::ACT_TICK, 15'd600);
    send_word(rsrp_pkg::ACT_TICK, 15'd600);
    send_word(rsrp_pkg::ACT_TICK, 15'd600);
    send_word(rsrp_pkg::ACT_TICK, 15'd600);
    send_word(rsrp_pkg::ACT_ABORT, 15'd600);
    send_word(rsrp_pkg::ACT_RESTART, 15'd0);
  endtask

  task automatic test_directed_extremes();
    // Largest step with zero hold and dwell walks a whole cycle in four ticks.
    set_profile(32767, 0, 0);
    repeat (4) send_word(rsrp_pkg::ACT_TICK, 15'h7FFF);
    send_word(rsrp_pkg::ACT_TICK, 15'h7FFF);
    send_word(rsrp_pkg::ACT_ABORT, 15'h7FFF);
    send_word(rsrp_pkg::ACT_NOP, 15'h5555);
    repeat (3) send_word(rsrp_pkg::ACT_TICK, 15'h7FFF);
    send_word(rsrp_pkg::ACT_RESTART, 15'h2AAA);
    // A zero step only moves on when the goal already equals the target.
    set_profile(0, 0, 0);
    repeat (4) send_word(rsrp_pkg::ACT_TICK, 15'd0);
    send_word(rsrp_pkg::ACT_TICK, 15'd5);
    send_word(rsrp_pkg::ACT_TICK, 15'd0);
    send_word(rsrp_pkg::ACT_RESTART, 15'd0);
    // Goal drops below the target during the ramp, with the longest counts.
    set_profile(1, 65535, 65535);
    send_word(rsrp_pkg::ACT_TICK, 15'd3);
    send_word(rsrp_pkg::ACT_TICK, 15'd3);
    send_word(rsrp_pkg::ACT_TICK, 15'd1);
    send_word(rsrp_pkg::ACT_TICK, 15'd1);
    send_word(rsrp_pkg::ACT_ABORT, 15'd1);
    send_word(rsrp_pkg::ACT_RESTART, 15'd1);
  endtask

  function automatic logic [rsrp_pkg::CmdW-1:0] pick_command();
    case ($urandom_range(0, 3))
      0:       return rsrp_pkg::CmdW'($urandom_range(0, 64));
      1:       return 15'h7FFF;
      default: return rsrp_pkg::CmdW'($urandom_range(0, 32767));
    endcase
  endfunction

  // Mostly ticks toward a steady command, with some goal changes and noise.
  task automatic run_profile(int n_words, logic [rsrp_pkg::CmdW-1:0] cmd);
    int                pick;
    rsrp_pkg::action_t act;
    for (int i = 0; i < n_words; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) act = rsrp_pkg::ACT_ABORT;
      else if (pick < 7) act = rsrp_pkg::ACT_RESTART;
      else if (pick < 9) act = rsrp_pkg::ACT_NOP;
      else act = rsrp_pkg::ACT_TICK;
      if ($urandom_range(0, 11) == 0) cmd = pick_command();
      send_word(act, cmd);
    end
  endtask

  task automatic run_random_setting(int n_words);
    logic [rsrp_pkg::CmdW-1:0] cmd;
    int                        step;
    cmd = pick_command();
    if ($urandom_range(0, 3) == 0) step = $urandom_range(1, 32767);
    else step = int'(cmd) / $urandom_range(1, 6);
    if (step == 0) step = 1;
    set_profile(step, $urandom_range(0, 6), $urandom_range(0, 6));
    run_profile(n_words, cmd);
  endtask

  task automatic test_random_profiles();
    repeat (5) run_random_setting(80);
    // Reset register values, long enough for a full reversal.
    set_profile(int'(rsrp_pkg::RampStepRst), int'(rsrp_pkg::HoldRst),
                int'(rsrp_pkg::DwellRst));
    run_profile(160, rsrp_pkg::CmdW'($urandom_range(256, 2048)));
  endtask

  // The output side stops for a long stretch while words keep coming.
  task automatic test_backpressure();
    stall_requests++;
    run_profile(40, pick_command());
  endtask

  task automatic test_no_idle();
    drain();
    idle_on = 1'b0;
    run_random_setting(80);
  endtask

  always @(negedge clk) begin
    if (stall_grants != stall_requests) begin
      stall_grants++;
      rx_wait = 40;
    end
    if (rx_wait > 0) begin
      rx_wait--;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      rx_wait = $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_word = rsrp_pkg::prof_result_t'(out_tdata[$bits(rsrp_pkg::prof_result_t)-1:0]);
      if (results_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected output word %h", out_tdata);
      end else begin
        due_word = results_due.pop_front();
        if (got_word.target_speed !== due_word.target_speed ||
            got_word.target_valid !== due_word.target_valid ||
            got_word.stop_pulse !== due_word.stop_pulse ||
            got_word.profile_phase !== due_word.profile_phase ||
            got_word.reverse_sign !== due_word.reverse_sign) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected speed %0d valid %b stop %b phase %0d rev %b",
                     due_word.target_speed, due_word.target_valid, due_word.stop_pulse,
                     due_word.profile_phase, due_word.reverse_sign);
            $display("          got speed %0d valid %b stop %b phase %0d rev %b",
                     got_word.target_speed, got_word.target_valid, got_word.stop_pulse,
                     got_word.profile_phase, got_word.reverse_sign);
          end
        end
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = rsrp_pkg::ACT_TICK;
    reg_ramp_step = int'(rsrp_pkg::RampStepRst);
    reg_hold      = int'(rsrp_pkg::HoldRst);
    reg_dwell     = int'(rsrp_pkg::DwellRst);
    clear_profile();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_values();
    test_directed_extremes();
    test_random_profiles();
    test_backpressure();
    test_no_idle();

    drain();
    repeat (10) @(negedge clk);
    if (results_due.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rsrp_pkg.sv
rtl/rsrp_step.sv
rtl/reversing_speed_ramp_profile_top.sv
dv/tb_reversing_speed_ramp_profile_top.sv
